[design/dpw_pkg.sv]
// Shared types and constants for the DPW pulse oscillator.
// No dependencies; used by dpw_ctrl, dpw_dpath and dpw_pulse_oscillator.
package dpw_pkg;

   localparam int TABLE_DEPTH_DEF = 256;

   // word commands
   localparam logic [1:0] CMD_SAMPLE = 2'd0;
   localparam logic [1:0] CMD_LOAD_COARSE = 2'd1;
   localparam logic [1:0] CMD_LOAD_FINE = 2'd2;

   // fixed arithmetic constants
   localparam logic signed [17:0] PITCH_OFFSET = 18'sh08000;
   localparam logic signed [17:0] PITCH_MAX = 18'sd65535;
   localparam logic [30:0] LEVEL_DIVIDEND = 31'h70000000;
   localparam logic [26:0] LEVEL_SAT = 27'h7FFFFFF;
   // quotient exceeds saturation for any divisor below this
   localparam logic [17:0] LEVEL_MIN_DIV = 18'd15;
   localparam logic [4:0] DIV_TOP_BIT = 5'd30;

   // multiplier operand selection
   typedef enum logic [2:0] {
      MUL_INC = 3'd0,
      MUL_SQ1 = 3'd1,
      MUL_SQ2 = 3'd2,
      MUL_SAW1 = 3'd3,
      MUL_SAW2 = 3'd4
   } mul_sel_type;

   // controller to datapath
   typedef struct packed {
      logic        take_req;
      logic        rd_tab;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        ph_step;
      logic        sq1_cap;
      logic        sq2_cap;
      logic        div_start;
      logic        div_sel;
      logic        div_step;
      logic        l1_cap;
      logic        l2_cap;
      logic        saw1_cap;
      logic        finish;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic div_last;
   } status_type;

endpackage

[design/dpw_pulse_oscillator.sv]
// Top level of the DPW pulse oscillator: sequencer plus datapath.
// Depends on dpw_pkg, dpw_ctrl and dpw_dpath.
//
//   channel | direction | handshake           | word
//   req_    | in        | req_valid/req_stall | cmd, pitch, pulse_width, index, value
//   rsp_    | out       | rsp_valid/rsp_stall | sample
//
// A sample word passes through a table read, five multiplier passes and
// two passes of the 31-step level divider before it reaches the output.
// Table load words and unused commands are taken without leaving idle.
// Reset clears the phase and history; table contents stay undefined.
// A stalled output holds the finished sample; the next sample waits in ST_OUT.
module dpw_pulse_oscillator import dpw_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_cmd,
   input  logic signed [16:0] req_pitch,
   input  logic [31:0]        req_pulse_width,
   input  logic [7:0]         req_table_index,
   input  logic [31:0]        req_table_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_sample
);

   cmd_type    cmd;
   status_type status;

   dpw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   dpw_dpath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_cmd         (req_cmd),
      .req_pitch       (req_pitch),
      .req_pulse_width (req_pulse_width),
      .req_table_index (req_table_index),
      .req_table_value (req_table_value),
      .rsp_sample      (rsp_sample)
   );

endmodule

[design/dpw_ctrl.sv]
// Sequencer for the DPW pulse oscillator: walks one sample word through
// the datapath and owns the handshake flags. Depends on dpw_pkg.
module dpw_ctrl import dpw_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [1:0] req_cmd,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [12:0] {
      ST_IDLE  = 13'h0001,
      ST_READ  = 13'h0002,
      ST_MINC  = 13'h0004,
      ST_PH    = 13'h0008,
      ST_SQ1   = 13'h0010,
      ST_SQ2   = 13'h0020,
      ST_SQ2W  = 13'h0040,
      ST_DIV1  = 13'h0080,
      ST_DIV2S = 13'h0100,
      ST_DIV2  = 13'h0200,
      ST_SAW1  = 13'h0400,
      ST_SAW2  = 13'h0800,
      ST_OUT   = 13'h1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      out_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd = '0;
      cmd.mul_sel = MUL_INC;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.take_req = accept;
            if (accept && req_cmd == CMD_SAMPLE) state_in = ST_READ;
         end
         ST_READ: begin
            cmd.rd_tab = 1'b1;
            state_in = ST_MINC;
         end
         ST_MINC: begin
            cmd.mul_en = 1'b1;
            cmd.mul_sel = MUL_INC;
            state_in = ST_PH;
         end
         ST_PH: begin
            cmd.ph_step = 1'b1;
            state_in = ST_SQ1;
         end
         ST_SQ1: begin
            cmd.mul_en = 1'b1;
            cmd.mul_sel = MUL_SQ1;
            state_in = ST_SQ2;
         end
         ST_SQ2: begin
            cmd.sq1_cap = 1'b1;
            cmd.mul_en = 1'b1;
            cmd.mul_sel = MUL_SQ2;
            state_in = ST_SQ2W;
         end
         ST_SQ2W: begin
            cmd.sq2_cap = 1'b1;
            cmd.div_start = 1'b1;
            cmd.div_sel = 1'b0;
            state_in = ST_DIV1;
         end
         ST_DIV1: begin
            cmd.div_step = 1'b1;
            if (status.div_last) state_in = ST_DIV2S;
         end
         ST_DIV2S: begin
            cmd.l1_cap = 1'b1;
            cmd.div_start = 1'b1;
            cmd.div_sel = 1'b1;
            state_in = ST_DIV2;
         end
         ST_DIV2: begin
            cmd.div_step = 1'b1;
            if (status.div_last) state_in = ST_SAW1;
         end
         ST_SAW1: begin
            cmd.l2_cap = 1'b1;
            cmd.mul_en = 1'b1;
            cmd.mul_sel = MUL_SAW1;
            state_in = ST_SAW2;
         end
         ST_SAW2: begin
            cmd.saw1_cap = 1'b1;
            cmd.mul_en = 1'b1;
            cmd.mul_sel = MUL_SAW2;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // hold until the output register is free
            if (out_free) begin
               cmd.finish = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // output valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.finish) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef ASSERT_OFF
   a_finish_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid_ff)
      else $error("finished sample not presented");
   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> rsp_valid_ff)
      else $error("stalled output word dropped");
   a_sample_start: assert property (@(posedge clock) disable iff (reset)
      (accept && req_cmd == CMD_SAMPLE) |=> (state_ff == ST_READ))
      else $error("sample word not started");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> out_free)
      else $error("output overwritten while stalled");
`endif

endmodule

[design/dpw_dpath.sv]
// Datapath for the DPW pulse oscillator: pitch tables, shared multiplier,
// radix-2 level divider and oscillator state. Depends on dpw_pkg.
module dpw_dpath import dpw_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output status_type         status,
   input  logic [1:0]         req_cmd,
   input  logic signed [16:0] req_pitch,
   input  logic [31:0]        req_pulse_width,
   input  logic [7:0]         req_table_index,
   input  logic [31:0]        req_table_value,
   output logic signed [31:0] rsp_sample
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);

   logic [31:0] coarse_mem [TABLE_DEPTH];
   logic [31:0] fine_mem [TABLE_DEPTH];

   logic [31:0] coarse_q_ff, fine_q_ff;
   logic [15:0] p_ff, p_in;
   logic [31:0] pw_ff;
   logic [31:0] phase_acc_ff, ph_ff, ph2_ff;
   logic [30:0] prev_main_ff, prev_off_ff;
   logic [31:0] prev_width_ff;
   logic [31:0] mulhi_ff, sq1_ff, sq2_ff, saw1_ff;
   logic [17:0] d1_ff, d2_ff, div_d_ff, rem_ff, rem_in;
   logic [30:0] quo_ff;
   logic [4:0]  cnt_ff;
   logic [26:0] l1_ff, l2_ff, level;
   logic [31:0] sample_ff;

   logic signed [17:0] pitch_off;
   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] product;
   logic [31:0] inc, ph_new, ph2_new, d2_sum, diff1, diff2, sample_new;
   logic [18:0] trial, trial_sub;
   logic        trial_ge;

   // pitch offset and clamp
   always_comb begin
      pitch_off = 18'(req_pitch) + PITCH_OFFSET;
      priority if (pitch_off < 0) p_in = 16'd0;
      else if (pitch_off > PITCH_MAX) p_in = 16'hFFFF;
      else p_in = pitch_off[15:0];
   end

   // table writes on load words, registered reads
   always_ff @(posedge clock) begin
      if (cmd.take_req && req_cmd == CMD_LOAD_COARSE)
         coarse_mem[req_table_index[IDX_W-1:0]] <= req_table_value;
      if (cmd.rd_tab) coarse_q_ff <= coarse_mem[p_ff[15:16-IDX_W]];
   end

   always_ff @(posedge clock) begin
      if (cmd.take_req && req_cmd == CMD_LOAD_FINE)
         fine_mem[req_table_index[IDX_W-1:0]] <= req_table_value;
      if (cmd.rd_tab) fine_q_ff <= fine_mem[p_ff[IDX_W-1:0]];
   end

   // shared signed 33x33 multiplier, high word registered
   assign diff1 = sq1_ff - {1'b0, prev_main_ff};
   assign diff2 = sq2_ff - {1'b0, prev_off_ff};
   always_comb begin
      unique case (cmd.mul_sel)
         MUL_INC: begin
            mul_a = {1'b0, coarse_q_ff};
            mul_b = {1'b0, fine_q_ff};
         end
         MUL_SQ1: begin
            mul_a = {ph_ff[31], ph_ff};
            mul_b = {ph_ff[31], ph_ff};
         end
         MUL_SQ2: begin
            mul_a = {ph2_ff[31], ph2_ff};
            mul_b = {ph2_ff[31], ph2_ff};
         end
         MUL_SAW1: begin
            mul_a = {diff1[31], diff1};
            mul_b = {3'b000, l1_ff, 3'b000};
         end
         MUL_SAW2: begin
            mul_a = {diff2[31], diff2};
            mul_b = {3'b000, l2_ff, 3'b000};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end
   assign product = mul_a * mul_b;

   // phases and divisors
   assign inc = mulhi_ff;
   assign ph_new = phase_acc_ff + inc;
   assign ph2_new = ph_new + pw_ff;
   assign d2_sum = inc + ({1'b0, pw_ff[31:1]} - {1'b0, prev_width_ff[31:1]}) * 32'd2;

   // restoring divider step, one quotient bit a cycle
   assign trial = {rem_ff, LEVEL_DIVIDEND[cnt_ff]};
   assign trial_ge = trial >= {1'b0, div_d_ff};
   assign trial_sub = trial - {1'b0, div_d_ff};
   assign rem_in = trial_ge ? trial_sub[17:0] : trial[17:0];
   assign status.div_last = (cnt_ff == 5'd0);
   assign level = (div_d_ff < LEVEL_MIN_DIV) ? LEVEL_SAT : quo_ff[26:0];

   assign sample_new = (saw1_ff - mulhi_ff) << 14;

   always_ff @(posedge clock) begin
      if (cmd.take_req) begin
         p_ff <= p_in;
         pw_ff <= req_pulse_width;
      end
      if (cmd.mul_en) mulhi_ff <= product[63:32];
      if (cmd.ph_step) begin
         ph_ff <= ph_new;
         ph2_ff <= ph2_new;
         d1_ff <= inc[31:14];
         d2_ff <= d2_sum[31:14];
      end
      if (cmd.sq1_cap) sq1_ff <= mulhi_ff;
      if (cmd.sq2_cap) sq2_ff <= mulhi_ff;
      if (cmd.div_start) begin
         div_d_ff <= cmd.div_sel ? d2_ff : d1_ff;
         rem_ff <= '0;
         cnt_ff <= DIV_TOP_BIT;
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[29:0], trial_ge};
         cnt_ff <= cnt_ff - 5'd1;
      end
      if (cmd.l1_cap) l1_ff <= level;
      if (cmd.l2_cap) l2_ff <= level;
      if (cmd.saw1_cap) saw1_ff <= mulhi_ff;
      if (cmd.finish) sample_ff <= sample_new;
   end

   // oscillator state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_acc_ff <= '0;
         prev_main_ff <= '0;
         prev_off_ff <= '0;
         prev_width_ff <= '0;
      end else if (cmd.finish) begin
         phase_acc_ff <= ph_ff;
         prev_main_ff <= sq1_ff[30:0];
         prev_off_ff <= sq2_ff[30:0];
         prev_width_ff <= pw_ff;
      end
   end

   assign rsp_sample = sample_ff;

endmodule

[verif/tb_top.sv]
// Testbench for the DPW pulse oscillator: table loads, directed and random samples.
// Depends on dpw_pkg and dpw_pulse_oscillator; predicts each sample in the bench.
module tb_top;
   import dpw_pkg::*;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_cmd = CMD_SAMPLE;
   logic signed [16:0] req_pitch = '0;
   logic [31:0]        req_pulse_width = '0;
   logic [7:0]         req_table_index = '0;
   logic [31:0]        req_table_value = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_sample;

   localparam logic [1:0] CMD_UNUSED = 2'd3;

   dpw_pulse_oscillator dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // oscillator copy kept by the bench
   logic [31:0] osc_phase, osc_width;
   logic [30:0] osc_sq_main, osc_sq_off;
   logic [31:0] coarse_tab [256];
   logic [31:0] fine_tab [256];
   logic [31:0] sample_queue [$];
   int          errors = 0;
   bit          stim_done = 1'b0;
   bit          hold_long = 1'b0;

   typedef struct {
      logic [1:0]  cmd;
      logic [16:0] pitch;
      logic [31:0] pw;
      logic [7:0]  idx;
      logic [31:0] val;
   } word_type;

   function automatic logic [31:0] mul_hi(logic [31:0] a, logic [31:0] b);
      logic signed [63:0] p;
      p = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
      return p[63:32];
   endfunction

   function automatic logic [31:0] level_of(logic [31:0] d);
      logic [31:0] q;
      if (d == 0) return 32'h7FFFFFF;
      q = 32'h70000000 / d;
      return (q > 32'h7FFFFFF) ? 32'h7FFFFFF : q;
   endfunction

   // apply one word to the bench copy; queue a sample where one is due
   task automatic predict_word(word_type w);
      int          p;
      logic [63:0] prod;
      logic [31:0] inc, ph, ph2, sq1, sq2, l1, l2, dv2, saw1, saw2;
      case (w.cmd)
         CMD_LOAD_COARSE: coarse_tab[w.idx] = w.val;
         CMD_LOAD_FINE:   fine_tab[w.idx] = w.val;
         CMD_SAMPLE: begin
            p = $signed(w.pitch) + 32'sh8000;
            if (p < 0) p = 0;
            if (p > 65535) p = 65535;
            prod = 64'(coarse_tab[p[15:8]]) * 64'(fine_tab[p[7:0]]);
            inc = prod[63:32];
            ph = osc_phase + inc;
            ph2 = ph + w.pw;
            sq1 = mul_hi(ph, ph);
            sq2 = mul_hi(ph2, ph2);
            l1 = level_of(inc >> 14);
            dv2 = (inc + (((w.pw >> 1) - (osc_width >> 1)) << 1)) >> 14;
            l2 = level_of(dv2);
            osc_width = w.pw;
            saw1 = mul_hi(sq1 - {1'b0, osc_sq_main}, l1 << 3);
            saw2 = mul_hi(sq2 - {1'b0, osc_sq_off}, l2 << 3);
            osc_phase = ph;
            osc_sq_main = sq1[30:0];
            osc_sq_off = sq2[30:0];
            sample_queue.push_back((saw1 - saw2) << 14);
         end
         default: ;
      endcase
   endtask

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
      errors++;
   endtask

   // send one word, holding it until accepted
   task automatic send_word(word_type w);
      req_cmd <= w.cmd;
      req_pitch <= w.pitch;
      req_pulse_width <= w.pw;
      req_table_index <= w.idx;
      req_table_value <= w.val;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_word(w);
   endtask

   task automatic idle_gap();
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 150) : $urandom_range(0, 3);
      if ($urandom_range(0, 2) == 0) n = 0;
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   function automatic word_type mk(logic [1:0] c, logic [16:0] pt, logic [31:0] pw,
                                   logic [7:0] ix, logic [31:0] v);
      word_type w;
      w.cmd = c; w.pitch = pt; w.pw = pw; w.idx = ix; w.val = v;
      return w;
   endfunction

   // result side: random stalls plus one long hold-off
   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else if (hold_long) rsp_stall <= 1'b1;
      else rsp_stall <= ($urandom_range(0, 9) == 0) ? 1'b1 : ($urandom_range(0, 3) == 0);
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (sample_queue.size() == 0) report_mismatch("unexpected sample", rsp_sample, 'x);
         else begin
            logic [31:0] want;
            want = sample_queue.pop_front();
            if (rsp_sample !== want) report_mismatch("sample", rsp_sample, want);
         end
      end
   end

   // long receiver hold-off counted in cycles
   initial begin
      @(negedge reset);
      repeat (3000) @(posedge clock);
      hold_long = 1'b1;
      repeat (1500) @(posedge clock);
      hold_long = 1'b0;
   end

   // stimulus
   initial begin
      word_type dir [$];
      word_type w;
      int k;
      osc_phase = 0; osc_width = 0; osc_sq_main = 0; osc_sq_off = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // fill both tables fully so no sample reads an unwritten entry
      for (int i = 0; i < 256; i++) begin
         send_word(mk(CMD_LOAD_COARSE, '0, '0, i[7:0], (i == 0) ? 32'h0 : $urandom()));
         send_word(mk(CMD_LOAD_FINE, '0, '0, i[7:0], (i == 255) ? 32'hFFFFFFFF : $urandom()));
      end
      // directed rows: zero increment (divisor zero), pitch clamp ends, width extremes
      dir.push_back(mk(CMD_SAMPLE, 17'h10000, 32'h0, 8'h0, 32'h0));
      dir.push_back(mk(CMD_SAMPLE, 17'h0FFFF, 32'hFFFFFFFF, 8'h0, 32'h0));
      dir.push_back(mk(CMD_SAMPLE, 17'h0, 32'h80000000, 8'h0, 32'h0));
      dir.push_back(mk(CMD_SAMPLE, 17'h18000, 32'h0, 8'h0, 32'h0));
      dir.push_back(mk(CMD_SAMPLE, 17'h07FFF, 32'h12345678, 8'h0, 32'h0));
      dir.push_back(mk(CMD_UNUSED, 17'h1FFFF, 32'hFFFFFFFF, 8'hFF, 32'hFFFFFFFF));
      dir.push_back(mk(CMD_LOAD_COARSE, 17'h0, 32'h0, 8'hFF, 32'hFFFFFFFF));
      dir.push_back(mk(CMD_SAMPLE, 17'h0FFFF, 32'h0, 8'h0, 32'h0));
      dir.push_back(mk(CMD_SAMPLE, 17'h1FFFF, 32'h7FFFFFFF, 8'h0, 32'h0));
      foreach (dir[i]) begin
         send_word(dir[i]);
         idle_gap();
      end
      // random words: mostly samples, some loads, a few unused
      for (int n = 0; n < 2000; n++) begin
         k = $urandom_range(0, 19);
         w.cmd = (k < 15) ? CMD_SAMPLE : (k < 17) ? CMD_LOAD_COARSE :
                 (k < 19) ? CMD_LOAD_FINE : CMD_UNUSED;
         w.pitch = 17'($urandom());
         w.pw = $urandom();
         w.idx = 8'($urandom());
         w.val = $urandom();
         send_word(w);
         idle_gap();
      end
      req_valid <= 1'b0;
      stim_done = 1'b1;
   end

   // end of run
   initial begin
      wait (stim_done);
      while (sample_queue.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (errors == 0) $display("dpw_pulse_oscillator test passed");
      else $display("dpw_pulse_oscillator test failed");
      $finish;
   end

   initial begin
      #20000000;
      $display("dpw_pulse_oscillator test failed");
      $finish;
   end
endmodule
